@@ hw/rtl/kda_pkg.sv @@
// Shared constants, types and a helper function of the keypad debounce block.
package kda_pkg;

  localparam int KEY_COUNT      = 12;
  localparam int TIME_BITS      = 20;
  localparam int CFG_DATA_BITS  = (TIME_BITS > KEY_COUNT) ? TIME_BITS : KEY_COUNT;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [KEY_COUNT-1:0]      key_vec_t;
  typedef logic [TIME_BITS-1:0]      time_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  // Register indexes of the configuration port.
  localparam cfg_index_t CFG_DEBOUNCE_TIME = cfg_index_t'(0);
  localparam cfg_index_t CFG_REPEAT_DELAY  = cfg_index_t'(1);
  localparam cfg_index_t CFG_REPEAT_PERIOD = cfg_index_t'(2);
  localparam cfg_index_t CFG_REPEAT_ENABLE = cfg_index_t'(3);

  // Register values after reset.
  localparam time_t    DEBOUNCE_TIME_RST = time_t'(5000);
  localparam time_t    REPEAT_DELAY_RST  = time_t'(400000);
  localparam time_t    REPEAT_PERIOD_RST = time_t'(150000);
  localparam key_vec_t REPEAT_ENABLE_RST = key_vec_t'(12'h0CF);
  localparam key_vec_t KEYS_RELEASED     = '1;
  localparam time_t    TIME_MAX          = '1;

  // Repeat state of one key.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_WAIT   = 3'b010,
    PH_REPEAT = 3'b100
  } phase_t;

  // Per-key control handed from the top level to each repeat unit.
  typedef struct packed {
    logic step;     // a poll is being processed this cycle
    logic enabled;  // auto-repeat allowed for this key
    logic down;     // debounced level says pressed
    logic press;    // press edge on this poll
  } key_ctrl_t;

  // Saturating add of two time values.
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/kda_if.sv @@
// Handshake interfaces for the poll items and the result items.
interface kda_in_if;
  logic                  valid;
  logic                  ready;
  kda_pkg::key_vec_t     raw_keys;
  kda_pkg::time_t        elapsed_us;

  modport source (output valid, output raw_keys, output elapsed_us, input ready);
  modport sink   (input valid, input raw_keys, input elapsed_us, output ready);
endinterface

interface kda_out_if;
  logic                  valid;
  logic                  ready;
  kda_pkg::key_vec_t     key_levels;
  kda_pkg::key_vec_t     press_edges;
  kda_pkg::key_vec_t     release_edges;
  kda_pkg::key_vec_t     repeat_events;

  modport source (output valid, output key_levels, output press_edges,
                  output release_edges, output repeat_events, input ready);
  modport sink   (input valid, input key_levels, input press_edges,
                  input release_edges, input repeat_events, output ready);
endinterface

@@ hw/rtl/keypad_debounce_autorepeat_top.sv @@
// Top level of the keypad debounce and typematic repeat block.
//
// Usage: each item on in_ch is one poll of the keypad: twelve raw active-low
// key levels and the microseconds elapsed since the previous poll. For every
// poll exactly one item leaves on out_ch with the debounced levels, the press
// and release edges against the previous poll, and the repeat events of held
// keys whose auto-repeat is enabled.
// A poll is captured in the input register; its result is then loaded into the
// output register, where out_ch.valid shows it. Throughput is one poll per
// cycle while the receiver does not stall; the path between the registers
// is one saturating time add and compare for the sample decision, followed by
// one per-key saturating add and compare for the twelve repeat timers.
// When the receiver stalls, the result stays in the output register and the
// input register still takes one more poll; after that in_ch.ready drops until
// out_ch.ready returns. Nothing is lost or repeated.
// Reset (rst_n low at a clock edge) loads the default register values, marks
// all keys released, idles every repeat timer and sets the time since the
// last sample to its maximum, so the first poll always samples the keys.
// The user writes configuration via cfg_we, cfg_index and cfg_data only while
// no poll is in flight (unenforced); writes to unknown indexes are ignored.
module keypad_debounce_autorepeat_top (
  input  logic                  clk,
  input  logic                  rst_n,
  kda_in_if.sink                in_ch,
  kda_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  kda_pkg::cfg_index_t   cfg_index,
  input  kda_pkg::cfg_data_t    cfg_data
);
  import kda_pkg::*;

  // Configuration registers.
  time_t    debounce_time_r;
  time_t    repeat_delay_r;
  time_t    repeat_period_r;
  key_vec_t repeat_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= DEBOUNCE_TIME_RST;
      repeat_delay_r  <= REPEAT_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
      repeat_enable_r <= REPEAT_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_data[TIME_BITS-1:0];
        CFG_REPEAT_DELAY:  repeat_delay_r  <= cfg_data[TIME_BITS-1:0];
        CFG_REPEAT_PERIOD: repeat_period_r <= cfg_data[TIME_BITS-1:0];
        CFG_REPEAT_ENABLE: repeat_enable_r <= cfg_data[KEY_COUNT-1:0];
        default: begin
          // Unknown index: the write is dropped.
          debounce_time_r <= debounce_time_r;
        end
      endcase
    end
  end

  // Input register. It advances whenever the output register is free or
  // being emptied in this cycle.
  logic     in_v_r;
  key_vec_t raw_r;
  time_t    dt_r;
  logic     advance;
  logic     step;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign step        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r <= in_ch.raw_keys;
      dt_r  <= in_ch.elapsed_us;
    end
  end

  // Debounce: the held sample is also the previous poll's level, so the
  // edges compare the new sample against it.
  key_vec_t sampled_r, sampled_nxt;
  time_t    since_r, since_nxt;
  time_t    since_sum;
  logic     take_sample;
  key_vec_t presses;
  key_vec_t releases;
  key_vec_t repeats;

  always_comb begin
    since_sum   = sat_add(since_r, dt_r);
    take_sample = (since_sum >= debounce_time_r);
    sampled_nxt = take_sample ? raw_r : sampled_r;
    since_nxt   = take_sample ? '0 : since_sum;
    presses     = ~sampled_nxt & sampled_r;
    releases    = sampled_nxt & ~sampled_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sampled_r <= KEYS_RELEASED;
      since_r   <= TIME_MAX;
    end else if (step) begin
      sampled_r <= sampled_nxt;
      since_r   <= since_nxt;
    end
  end

  // One repeat unit per key, all stepping together.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    key_ctrl_t ctrl;

    assign ctrl.step    = step;
    assign ctrl.enabled = repeat_enable_r[k];
    assign ctrl.down    = !sampled_nxt[k];
    assign ctrl.press   = presses[k];

    kda_key_repeat u_rpt (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .dt       (dt_r),
      .delay    (repeat_delay_r),
      .period   (repeat_period_r),
      .rpt_fire (repeats[k])
    );
  end

  // Output register.
  logic     out_v_r;
  key_vec_t levels_r;
  key_vec_t presses_r;
  key_vec_t releases_r;
  key_vec_t repeats_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      levels_r   <= sampled_nxt;
      presses_r  <= presses;
      releases_r <= releases;
      repeats_r  <= repeats;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.key_levels    = levels_r;
  assign out_ch.press_edges   = presses_r;
  assign out_ch.release_edges = releases_r;
  assign out_ch.repeat_events = repeats_r;

`ifndef SYNTHESIS
  // A key cannot be pressed and released on the same poll.
  a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.press_edges & out_ch.release_edges) == '0))
    else $error("press and release edge on the same key");

  // Repeat events only come from keys that are down, and never on the press.
  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (((out_ch.repeat_events & out_ch.key_levels) == '0) &&
                      ((out_ch.repeat_events & out_ch.press_edges) == '0)))
    else $error("repeat event on a released key or on a press edge");

  // Repeat events only for keys with auto-repeat enabled.
  a_repeat_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> ((repeats & ~repeat_enable_r) == '0))
    else $error("repeat event on a disabled key");

  // With both registers full and the receiver stalled, no poll is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("poll accepted while the pipeline is full");
`endif

endmodule

@@ hw/rtl/kda_key_repeat.sv @@
// Typematic repeat state and timer of one key.
module kda_key_repeat (
  input  logic                clk,
  input  logic                rst_n,
  input  kda_pkg::key_ctrl_t  ctrl,
  input  kda_pkg::time_t      dt,
  input  kda_pkg::time_t      delay,
  input  kda_pkg::time_t      period,
  output logic                rpt_fire
);
  import kda_pkg::*;

  phase_t phase_r, phase_nxt;
  time_t  timer_r, timer_nxt;
  time_t  sum;
  time_t  limit;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    rpt_fire  = 1'b0;
    sum       = sat_add(timer_r, dt);
    limit     = (phase_r == PH_WAIT) ? delay : period;
    if (!ctrl.enabled || !ctrl.down) begin
      phase_nxt = PH_IDLE;
      timer_nxt = '0;
    end else if (ctrl.press) begin
      phase_nxt = PH_WAIT;
      timer_nxt = '0;
    end else begin
      case (phase_r)
        PH_WAIT, PH_REPEAT: begin
          timer_nxt = sum;
          if (sum >= limit) begin
            rpt_fire  = 1'b1;
            phase_nxt = PH_REPEAT;
            timer_nxt = '0;
          end
        end
        default: begin
          // Idle, or a code that means nothing: wait for the next press.
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
    end else if (ctrl.step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule
